/* rtl/core/tabc_pkg.sv */
`default_nettype none
package tabc_pkg;

  localparam int CHANNELS   = 2;
  localparam int CH_W       = 1;
  localparam int ADC_BITS   = 10;
  localparam int FULL_SCALE = (1 << ADC_BITS) - 1;

  localparam int LN2_Q16      = 45426;
  localparam int ZERO_C_CENTI = 27315;
  localparam int TEMP_MAX     = 32767;
  // largest quotient that still fits below the saturation limit
  localparam int QUO_MAX      = TEMP_MAX + ZERO_C_CENTI;
  localparam int DIV_STEPS    = 54;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_COUNT   = 3'd0,
    REG_BETA_KELVIN    = 3'd1,
    REG_NOMINAL_OHMS   = 3'd2,
    REG_SERIES_OHMS    = 3'd3,
    REG_NOMINAL_TEMP_C = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    STAT_VALID = 2'd0,
    STAT_ZERO  = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [ADC_BITS-1:0] sample;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0]    out_channel;
    logic signed [15:0] temp_centi_c;
    logic [1:0]         status;
  } out_t;

endpackage
`default_nettype wire

/* rtl/core/thermistor_average_beta_convert.sv */
// Thermistor averager and Beta-equation converter.
// Input channel (in_valid/in_ready/in_data): one ADC sample tagged with a probe.
// Each sample is added to its probe's running sum. When the probe has collected
// sample_count samples a conversion starts and in_ready stays low until its
// result has been placed in the output register.
// Result channel (out_valid/out_ready/out_data): one transaction per finished
// conversion carrying probe, temperature in 0.01 C and status.
// All products run through one bit-serial shift-add multiplier (two logarithms
// of 16 squarings each), a normalising shifter moves one bit a cycle and a
// 54-step restoring divider produces the quotient one bit a cycle. An average
// of zero or full scale skips the arithmetic.
// A stalled receiver holds the result in the output register; the block still
// takes further samples, and only a second finished result waits for it.
// Configuration (cfg_we/cfg_index/cfg_wdata) must be written while idle; the block does not enforce it.
// Synchronous reset clears sums, counts and the output valid flag and loads the
// default register values.
`default_nettype none
module thermistor_average_beta_convert #(
  parameter int MAX_SAMPLES = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire tabc_pkg::in_t                      in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output tabc_pkg::out_t                          out_data,
  input  wire logic                               cfg_we,
  input  wire logic [tabc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tabc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int SW = $clog2(tabc_pkg::FULL_SCALE * MAX_SAMPLES + 1);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int NW = (CW > 5) ? CW : 5;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_PROD = 9'b000000010,
    ST_NORM = 9'b000000100,
    ST_SQR  = 9'b000001000,
    ST_LN   = 9'b000010000,
    ST_BT   = 9'b000100000,
    ST_LT   = 9'b001000000,
    ST_DIV  = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [4:0]  sc_r, sc_nxt;
  logic [13:0] beta_r, beta_nxt;
  logic [19:0] nom_r, nom_nxt;
  logic [19:0] ser_r, ser_nxt;
  logic [6:0]  t0_r, t0_nxt;

  logic [SW-1:0] sum_r [tabc_pkg::CHANNELS];
  logic [SW-1:0] sum_nxt [tabc_pkg::CHANNELS];
  logic [CW-1:0] cnt_r [tabc_pkg::CHANNELS];
  logic [CW-1:0] cnt_nxt [tabc_pkg::CHANNELS];

  logic [tabc_pkg::CH_W-1:0] ch_r, ch_nxt;
  logic [SW-1:0] diff_r, diff_nxt;

  logic [63:0] mcand_r, mcand_nxt;
  logic [31:0] mplier_r, mplier_nxt;
  logic [63:0] acc_r, acc_nxt;

  logic [63:0] x_r, x_nxt;
  logic [5:0]  k_r, k_nxt;
  logic [30:0] m_r, m_nxt;
  logic [15:0] frac_r, frac_nxt;
  logic [3:0]  iter_r, iter_nxt;
  logic        lsel_r, lsel_nxt;
  logic [21:0] lgn_r, lgn_nxt;

  logic [21:0] lqm_r, lqm_nxt;
  logic        lqn_r, lqn_nxt;
  logic [36:0] bt100_r, bt100_nxt;
  logic [38:0] den_r, den_nxt;
  logic [53:0] dv_r, dv_nxt;
  logic [38:0] rem_r, rem_nxt;
  logic [53:0] quo_r, quo_nxt;
  logic [5:0]  dcnt_r, dcnt_nxt;

  logic [15:0] res_temp_r, res_temp_nxt;
  logic [1:0]  res_stat_r, res_stat_nxt;
  logic        out_valid_r, out_valid_nxt;
  tabc_pkg::out_t out_r, out_nxt;

  // combinational helpers
  logic [tabc_pkg::CH_W-1:0] ch_in;
  logic [SW-1:0]  nsum, fsn;
  logic [CW-1:0]  ncnt;
  logic [NW-1:0]  need, sc_e;
  logic [19:0]    nom_eff, ser_eff;
  logic [15:0]    t0c;
  logic [20:0]    b100;
  logic           mul_done;
  logic [31:0]    sq;
  logic [30:0]    m_new;
  logic [15:0]    frac_new;
  logic [21:0]    lg;
  logic [39:0]    bias40, lt40, den40;
  logic [39:0]    rem_t;
  logic           qbit;
  logic [53:0]    q_fin;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign ch_in   = in_data.channel;
  assign nom_eff = (nom_r == '0) ? 20'd1 : nom_r;
  assign ser_eff = (ser_r == '0) ? 20'd1 : ser_r;
  assign t0c     = 16'(16'(t0_r) * 16'd100) + 16'(tabc_pkg::ZERO_C_CENTI);
  assign b100    = 21'(beta_r) * 21'd100;
  assign sc_e    = NW'(sc_r);
  assign need    = (sc_r == '0) ? NW'(1) :
                   (sc_e > NW'(MAX_SAMPLES)) ? NW'(MAX_SAMPLES) : sc_e;
  assign mul_done = (mplier_r == '0);

  // squaring step of the logarithm
  assign sq       = acc_r[61:30];
  assign m_new    = sq[31] ? sq[31:1] : sq[30:0];
  assign frac_new = {frac_r[14:0], sq[31]};
  assign lg       = {6'd63 - k_r, frac_new};

  assign bias40 = {3'b000, b100, 16'h0000};
  assign lt40   = {2'b00, acc_r[37:0]};
  assign den40  = lqn_r ? (bias40 - lt40) : (bias40 + lt40);

  assign rem_t = {rem_r, dv_r[53]};
  assign qbit  = (rem_t >= {1'b0, den_r});
  assign q_fin = {quo_r[52:0], qbit};

  always_comb begin
    nsum = sum_r[ch_in] + SW'(in_data.sample);
    ncnt = cnt_r[ch_in] + CW'(1);
    fsn  = (SW'(ncnt) << tabc_pkg::ADC_BITS) - SW'(ncnt);
  end

  always_comb begin
    state_nxt = state_r;
    sc_nxt = sc_r;
    beta_nxt = beta_r;
    nom_nxt = nom_r;
    ser_nxt = ser_r;
    t0_nxt = t0_r;
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    ch_nxt = ch_r;
    diff_nxt = diff_r;
    x_nxt = x_r;
    k_nxt = k_r;
    m_nxt = m_r;
    frac_nxt = frac_r;
    iter_nxt = iter_r;
    lsel_nxt = lsel_r;
    lgn_nxt = lgn_r;
    lqm_nxt = lqm_r;
    lqn_nxt = lqn_r;
    bt100_nxt = bt100_r;
    den_nxt = den_r;
    dv_nxt = dv_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dcnt_nxt = dcnt_r;
    res_temp_nxt = res_temp_r;
    res_stat_nxt = res_stat_r;
    // output register defaults: drop the held result once it is taken
    out_valid_nxt = out_valid_r;
    out_nxt = out_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    // shared shift-add multiplier, one multiplier bit per cycle
    mcand_nxt = mcand_r;
    mplier_nxt = mplier_r;
    acc_nxt = acc_r;
    if (!mul_done) begin
      if (mplier_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt = mcand_r << 1;
      mplier_nxt = mplier_r >> 1;
    end

    if (cfg_we) begin
      unique case (cfg_index)
        tabc_pkg::REG_SAMPLE_COUNT:   sc_nxt = cfg_wdata[4:0];
        tabc_pkg::REG_BETA_KELVIN:    beta_nxt = cfg_wdata[13:0];
        tabc_pkg::REG_NOMINAL_OHMS:   nom_nxt = cfg_wdata[19:0];
        tabc_pkg::REG_SERIES_OHMS:    ser_nxt = cfg_wdata[19:0];
        tabc_pkg::REG_NOMINAL_TEMP_C: t0_nxt = cfg_wdata[6:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && (32'(ch_in) < tabc_pkg::CHANNELS)) begin
          if (NW'(ncnt) >= need) begin
            sum_nxt[ch_in] = '0;
            cnt_nxt[ch_in] = '0;
            ch_nxt = ch_in;
            res_temp_nxt = '0;
            if (nsum == '0) begin
              res_stat_nxt = tabc_pkg::STAT_ZERO;
              state_nxt = ST_DONE;
            end else if (nsum >= fsn) begin
              res_stat_nxt = tabc_pkg::STAT_FULL;
              state_nxt = ST_DONE;
            end else begin
              res_stat_nxt = tabc_pkg::STAT_VALID;
              diff_nxt = fsn - nsum;
              lsel_nxt = 1'b0;
              mcand_nxt = 64'(ser_eff);
              mplier_nxt = 32'(nsum);
              acc_nxt = '0;
              state_nxt = ST_PROD;
            end
          end else begin
            sum_nxt[ch_in] = nsum;
            cnt_nxt[ch_in] = ncnt;
          end
        end
      end
      ST_PROD: begin
        if (mul_done) begin
          x_nxt = acc_r;
          k_nxt = '0;
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if (!x_r[63]) begin
          x_nxt = x_r << 1;
          k_nxt = k_r + 6'd1;
        end else begin
          m_nxt = x_r[63:33];
          frac_nxt = '0;
          iter_nxt = '0;
          mcand_nxt = 64'(x_r[63:33]);
          mplier_nxt = 32'(x_r[63:33]);
          acc_nxt = '0;
          state_nxt = ST_SQR;
        end
      end
      ST_SQR: begin
        if (mul_done) begin
          m_nxt = m_new;
          frac_nxt = frac_new;
          iter_nxt = iter_r + 4'd1;
          acc_nxt = '0;
          if (iter_r == 4'd15) begin
            if (!lsel_r) begin
              lgn_nxt = lg;
              lsel_nxt = 1'b1;
              mcand_nxt = 64'(nom_eff);
              mplier_nxt = 32'(diff_r);
              state_nxt = ST_PROD;
            end else begin
              // ln of the ratio: log2 difference scaled by ln 2, sign kept apart
              lqn_nxt = (lg > lgn_r);
              mcand_nxt = 64'((lg > lgn_r) ? (lg - lgn_r) : (lgn_r - lg));
              mplier_nxt = 32'(tabc_pkg::LN2_Q16);
              state_nxt = ST_LN;
            end
          end else begin
            mcand_nxt = 64'(m_new);
            mplier_nxt = 32'(m_new);
          end
        end
      end
      ST_LN: begin
        if (mul_done) begin
          lqm_nxt = acc_r[37:16];
          mcand_nxt = 64'(beta_r);
          mplier_nxt = 32'(t0c);
          acc_nxt = '0;
          state_nxt = ST_BT;
        end
      end
      ST_BT: begin
        if (mul_done) begin
          bt100_nxt = 37'(acc_r[29:0]) * 37'd100;
          mcand_nxt = 64'(lqm_r);
          mplier_nxt = 32'(t0c);
          acc_nxt = '0;
          state_nxt = ST_LT;
        end
      end
      ST_LT: begin
        if (mul_done) begin
          if (den40[39] || (den40 == '0)) begin
            res_temp_nxt = 16'(tabc_pkg::TEMP_MAX);
            state_nxt = ST_DONE;
          end else begin
            den_nxt = den40[38:0];
            // rounding: add half the divisor before dividing
            dv_nxt = 54'({bt100_r, 16'h0000}) + 54'(den40[38:1]);
            rem_nxt = '0;
            quo_nxt = '0;
            dcnt_nxt = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_nxt = qbit ? 39'(rem_t - {1'b0, den_r}) : rem_t[38:0];
        quo_nxt = q_fin;
        dv_nxt = dv_r << 1;
        dcnt_nxt = dcnt_r + 6'd1;
        if (dcnt_r == 6'(tabc_pkg::DIV_STEPS - 1)) begin
          if (q_fin > 54'(tabc_pkg::QUO_MAX)) begin
            res_temp_nxt = 16'(tabc_pkg::TEMP_MAX);
          end else begin
            res_temp_nxt = 16'(17'(q_fin[16:0]) - 17'(tabc_pkg::ZERO_C_CENTI));
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_nxt.out_channel = ch_r;
          out_nxt.temp_centi_c = res_temp_r;
          out_nxt.status = res_stat_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sc_r <= 5'd5;
      beta_r <= 14'd3950;
      nom_r <= 20'd10000;
      ser_r <= 20'd10000;
      t0_r <= 7'd25;
      for (int i = 0; i < tabc_pkg::CHANNELS; i++) begin
        sum_r[i] <= '0;
        cnt_r[i] <= '0;
      end
      mplier_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sc_r <= sc_nxt;
      beta_r <= beta_nxt;
      nom_r <= nom_nxt;
      ser_r <= ser_nxt;
      t0_r <= t0_nxt;
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
      mplier_r <= mplier_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r <= ch_nxt;
    diff_r <= diff_nxt;
    mcand_r <= mcand_nxt;
    acc_r <= acc_nxt;
    x_r <= x_nxt;
    k_r <= k_nxt;
    m_r <= m_nxt;
    frac_r <= frac_nxt;
    iter_r <= iter_nxt;
    lsel_r <= lsel_nxt;
    lgn_r <= lgn_nxt;
    lqm_r <= lqm_nxt;
    lqn_r <= lqn_nxt;
    bt100_r <= bt100_nxt;
    den_r <= den_nxt;
    dv_r <= dv_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dcnt_r <= dcnt_nxt;
    res_temp_r <= res_temp_nxt;
    res_stat_r <= res_stat_nxt;
    out_r <= out_nxt;
  end

  a_div_positive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (den_r != '0))
    else $error("divider running with zero divisor");

  a_mantissa_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQR) |-> m_r[30])
    else $error("log mantissa not normalised");

  a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (mplier_r == '0))
    else $error("multiplier busy while idle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r[0] < CW'(MAX_SAMPLES)) && (cnt_r[tabc_pkg::CHANNELS-1] < CW'(MAX_SAMPLES)))
    else $error("sample count reached its limit without conversion");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result appeared outside the completion state");

endmodule
`default_nettype wire

/* tb/sv/tb_thermistor_average_beta_convert.sv */
`default_nettype none
module tb_thermistor_average_beta_convert;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SMP = 16;

  typedef enum logic {ROW_CFG, ROW_SMP} row_kind_t;

  typedef struct {
    row_kind_t kind;
    tabc_pkg::reg_idx_t idx;
    logic [tabc_pkg::CFG_DATA_W-1:0] val;
    tabc_pkg::in_t  smp;
    bit        fixed;
    tabc_pkg::out_t exp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tabc_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tabc_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [tabc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tabc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  thermistor_average_beta_convert u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // shadow of the block's registers and per-probe accumulators
  logic [4:0]  m_count = 5'd5;
  logic [13:0] m_beta = 14'd3950;
  logic [19:0] m_r0 = 20'd10000;
  logic [19:0] m_rs = 20'd10000;
  logic [6:0]  m_t0 = 7'd25;
  longint      m_sum [tabc_pkg::CHANNELS];
  longint      m_taken [tabc_pkg::CHANNELS];

  tabc_pkg::out_t temps_pending [$];
  int          errors = 0;
  int          burst_left = 0;
  stim_row_t   dir_rows [$];

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic longint log2_fix(longint unsigned n);
    longint unsigned t, m, frac;
    int p;
    if (n == 0) n = 1;
    t = n;
    p = 0;
    frac = 0;
    while ((t >> 1) != 0) begin
      t = t >> 1;
      p++;
    end
    if (p <= 30) m = n << (30 - p);
    else m = n >> (p - 30);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return longint'((longint'(p) << 16) | frac);
  endfunction

  function automatic longint beta_temp(longint sum, longint n);
    longint rs, r0, lq, t0c, b, num, den, tc;
    rs = (m_rs == 0) ? 1 : longint'(m_rs);
    r0 = (m_r0 == 0) ? 1 : longint'(m_r0);
    lq = ((log2_fix(rs * sum) - log2_fix(r0 * (tabc_pkg::FULL_SCALE * n - sum)))
          * tabc_pkg::LN2_Q16) / 65536;
    t0c = longint'(m_t0) * 100 + tabc_pkg::ZERO_C_CENTI;
    b = longint'(m_beta);
    num = b * t0c * 100 * 65536;
    den = lq * t0c + 100 * b * 65536;
    if (den <= 0) return tabc_pkg::TEMP_MAX;
    tc = (num + den / 2) / den - tabc_pkg::ZERO_C_CENTI;
    if (tc > tabc_pkg::TEMP_MAX) tc = tabc_pkg::TEMP_MAX;
    if (tc < -tabc_pkg::ZERO_C_CENTI) tc = -tabc_pkg::ZERO_C_CENTI;
    return tc;
  endfunction

  // accumulates one sample; returns 1 with the temperature when a conversion completes
  function automatic bit accumulate(tabc_pkg::in_t d, output tabc_pkg::out_t r);
    longint need, sum, n;
    int ch;
    ch = d.channel;
    need = m_count;
    if (need == 0) need = 1;
    if (need > MAX_SMP) need = MAX_SMP;
    m_sum[ch] += d.sample;
    m_taken[ch] += 1;
    r = '0;
    if (m_taken[ch] < need) return 0;
    sum = m_sum[ch];
    n = m_taken[ch];
    m_sum[ch] = 0;
    m_taken[ch] = 0;
    r.out_channel = d.channel;
    if (sum == 0) r.status = tabc_pkg::STAT_ZERO;
    else if (sum >= tabc_pkg::FULL_SCALE * n) r.status = tabc_pkg::STAT_FULL;
    else begin
      r.status = tabc_pkg::STAT_VALID;
      r.temp_centi_c = 16'(beta_temp(sum, n));
    end
    return 1;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic cfg_write(tabc_pkg::reg_idx_t idx, logic [tabc_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      tabc_pkg::REG_SAMPLE_COUNT:   m_count = val[4:0];
      tabc_pkg::REG_BETA_KELVIN:    m_beta = val[13:0];
      tabc_pkg::REG_NOMINAL_OHMS:   m_r0 = val[19:0];
      tabc_pkg::REG_SERIES_OHMS:    m_rs = val[19:0];
      tabc_pkg::REG_NOMINAL_TEMP_C: m_t0 = val[6:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (temps_pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // drives one sample with burst/gap pacing; returns after the transaction
  task automatic send_sample(tabc_pkg::in_t d, bit fixed, tabc_pkg::out_t fixed_exp);
    tabc_pkg::out_t r;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (accumulate(d, r)) temps_pending.push_back(fixed ? fixed_exp : r);
  endtask

  // receiver: stall pattern switches among always ready, random and mostly stalled modes
  int stall_left = 0;
  int stall_mode = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(50, 400);
    end
    stall_left--;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    tabc_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (temps_pending.size() == 0) begin
        report("unexpected transaction, channel", out_data.out_channel, -1);
      end else begin
        want = temps_pending.pop_front();
        if (out_data.out_channel !== want.out_channel)
          report("out_channel", out_data.out_channel, want.out_channel);
        if (out_data.temp_centi_c !== want.temp_centi_c)
          report("temp_centi_c", out_data.temp_centi_c, want.temp_centi_c);
        if (out_data.status !== want.status)
          report("status", out_data.status, want.status);
      end
    end
  end

  initial begin
    tabc_pkg::in_t  d;
    tabc_pkg::out_t nil;
    stim_row_t row;
    int   k;
    nil = '0;
    for (int c = 0; c < tabc_pkg::CHANNELS; c++) begin
      m_sum[c] = 0;
      m_taken[c] = 0;
    end

    dir_rows.push_back('{ROW_CFG, tabc_pkg::REG_SAMPLE_COUNT, 20'd1, '0, 1'b0, '0});
    dir_rows.push_back('{ROW_SMP, tabc_pkg::REG_SAMPLE_COUNT, '0, '{1'b0, 10'd0}, 1'b1,
                         '{1'b0, 16'sd0, tabc_pkg::STAT_ZERO}});
    dir_rows.push_back('{ROW_SMP, tabc_pkg::REG_SAMPLE_COUNT, '0, '{1'b1, 10'd1023}, 1'b1,
                         '{1'b1, 16'sd0, tabc_pkg::STAT_FULL}});
    dir_rows.push_back('{ROW_SMP, tabc_pkg::REG_SAMPLE_COUNT, '0, '{1'b0, 10'd512}, 1'b0, '0});
    dir_rows.push_back('{ROW_SMP, tabc_pkg::REG_SAMPLE_COUNT, '0, '{1'b1, 10'd1}, 1'b0, '0});
    dir_rows.push_back('{ROW_SMP, tabc_pkg::REG_SAMPLE_COUNT, '0, '{1'b0, 10'd1022}, 1'b0, '0});
    // beta of zero collapses to absolute zero
    dir_rows.push_back('{ROW_CFG, tabc_pkg::REG_BETA_KELVIN, 20'd0, '0, 1'b0, '0});
    dir_rows.push_back('{ROW_SMP, tabc_pkg::REG_SAMPLE_COUNT, '0, '{1'b0, 10'd1000}, 1'b1,
                         '{1'b0, -16'sd27315, tabc_pkg::STAT_VALID}});
    // tiny resistance drives the denominator negative
    dir_rows.push_back('{ROW_CFG, tabc_pkg::REG_BETA_KELVIN, 20'd1000, '0, 1'b0, '0});
    dir_rows.push_back('{ROW_CFG, tabc_pkg::REG_SERIES_OHMS, 20'd100, '0, 1'b0, '0});
    dir_rows.push_back('{ROW_CFG, tabc_pkg::REG_NOMINAL_OHMS, 20'd1000000, '0, 1'b0, '0});
    dir_rows.push_back('{ROW_SMP, tabc_pkg::REG_SAMPLE_COUNT, '0, '{1'b1, 10'd1}, 1'b1,
                         '{1'b1, 16'sd32767, tabc_pkg::STAT_VALID}});
    // ohms of zero read as one
    dir_rows.push_back('{ROW_CFG, tabc_pkg::REG_NOMINAL_OHMS, 20'd0, '0, 1'b0, '0});
    dir_rows.push_back('{ROW_CFG, tabc_pkg::REG_SERIES_OHMS, 20'd0, '0, 1'b0, '0});
    dir_rows.push_back('{ROW_SMP, tabc_pkg::REG_SAMPLE_COUNT, '0, '{1'b0, 10'd500}, 1'b0, '0});
    dir_rows.push_back('{ROW_CFG, tabc_pkg::REG_BETA_KELVIN, 20'd16383, '0, 1'b0, '0});
    dir_rows.push_back('{ROW_CFG, tabc_pkg::REG_NOMINAL_TEMP_C, 20'd127, '0, 1'b0, '0});
    dir_rows.push_back('{ROW_CFG, tabc_pkg::REG_SAMPLE_COUNT, 20'd0, '0, 1'b0, '0});
    dir_rows.push_back('{ROW_SMP, tabc_pkg::REG_SAMPLE_COUNT, '0, '{1'b1, 10'd700}, 1'b0, '0});
    // count above the maximum clamps, then lowering it converts at the next sample
    dir_rows.push_back('{ROW_CFG, tabc_pkg::REG_SAMPLE_COUNT, 20'd31, '0, 1'b0, '0});
    dir_rows.push_back('{ROW_SMP, tabc_pkg::REG_SAMPLE_COUNT, '0, '{1'b0, 10'd300}, 1'b0, '0});
    dir_rows.push_back('{ROW_SMP, tabc_pkg::REG_SAMPLE_COUNT, '0, '{1'b0, 10'd1023}, 1'b0, '0});
    dir_rows.push_back('{ROW_SMP, tabc_pkg::REG_SAMPLE_COUNT, '0, '{1'b0, 10'd0}, 1'b0, '0});
    dir_rows.push_back('{ROW_CFG, tabc_pkg::REG_SAMPLE_COUNT, 20'd2, '0, 1'b0, '0});
    dir_rows.push_back('{ROW_SMP, tabc_pkg::REG_SAMPLE_COUNT, '0, '{1'b0, 10'd600}, 1'b0, '0});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        wait_idle();
        cfg_write(row.idx, row.val);
      end else begin
        send_sample(row.smp, row.fixed, row.exp);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      if (ph == 0) begin
        cfg_write(tabc_pkg::REG_SAMPLE_COUNT, 20'd1);
        cfg_write(tabc_pkg::REG_BETA_KELVIN, 20'd1000);
        cfg_write(tabc_pkg::REG_NOMINAL_OHMS, 20'd100);
        cfg_write(tabc_pkg::REG_SERIES_OHMS, 20'd100);
        cfg_write(tabc_pkg::REG_NOMINAL_TEMP_C, 20'd0);
      end else if (ph == 1) begin
        cfg_write(tabc_pkg::REG_SAMPLE_COUNT, 20'd16);
        cfg_write(tabc_pkg::REG_BETA_KELVIN, 20'd10000);
        cfg_write(tabc_pkg::REG_NOMINAL_OHMS, 20'd1000000);
        cfg_write(tabc_pkg::REG_SERIES_OHMS, 20'd1000000);
        cfg_write(tabc_pkg::REG_NOMINAL_TEMP_C, 20'd100);
      end else begin
        k = $urandom_range(0, 9);
        cfg_write(tabc_pkg::REG_SAMPLE_COUNT, (k == 0) ? 20'd0 : (k == 1) ? 20'd31 :
                  20'($urandom_range(1, MAX_SMP)));
        k = $urandom_range(0, 9);
        cfg_write(tabc_pkg::REG_BETA_KELVIN, (k == 0) ? 20'd0 : (k == 1) ? 20'd16383 :
                  20'($urandom_range(1000, 10000)));
        k = $urandom_range(0, 7);
        cfg_write(tabc_pkg::REG_NOMINAL_OHMS, (k == 0) ? 20'd0 : (k == 1) ? 20'hFFFFF :
                  20'($urandom_range(100, 1000000)));
        k = $urandom_range(0, 7);
        cfg_write(tabc_pkg::REG_SERIES_OHMS, (k == 0) ? 20'd0 : (k == 1) ? 20'hFFFFF :
                  20'($urandom_range(100, 1000000)));
        k = $urandom_range(0, 7);
        cfg_write(tabc_pkg::REG_NOMINAL_TEMP_C,
                  (k == 0) ? 20'd127 : 20'($urandom_range(0, 100)));
      end
      for (int i = 0; i < 106; i++) begin
        d.channel = 1'($urandom_range(0, 1));
        k = $urandom_range(0, 7);
        d.sample = (k == 0) ? 10'd0 : (k == 1) ? 10'd1023 : 10'($urandom_range(0, 1023));
        send_sample(d, 1'b0, nil);
      end
    end

    in_valid <= 1'b0;
    while (temps_pending.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (errors == 0 && temps_pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
